FILE: sv/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg
// Types and constants shared by the clock frequency-locked-loop servo.
// ----------------------------------------------------------------------------
package cfs_pkg;

    // fixed point and limits
    localparam int unsigned FRAC_BITS       = 7;
    localparam logic [29:0] ABS_MAX_PPB     = 30'd900000000;
    localparam logic [63:0] EST_INTERVAL_NS = 64'd16000000000;

    // register reset values
    localparam logic [29:0]        MAX_PPB_RST       = 30'd900000000;
    localparam logic [46:0]        RESET_THR_RST     = 47'd0;
    localparam logic [46:0]        JUMP_THR_RST      = 47'd100;
    localparam logic signed [3:0]  INTERVAL_RST      = 4'sd0;
    localparam logic signed [3:0]  INTERVAL_MIN      = -4'sd7;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MAX_PPB   = 2'd0,
        REG_RESET_THR = 2'd1,
        REG_JUMP_THR  = 2'd2,
        REG_INTERVAL  = 2'd3
    } cfg_index_t;

    // sequencer phase
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_TRACK  = 2'd2
    } phase_t;

    // reported servo state
    typedef enum logic [1:0] {
        ST_UNLOCKED = 2'd0,
        ST_JUMP     = 2'd1,
        ST_LOCKED   = 2'd2
    } lock_state_t;

    typedef struct packed {
        logic signed [47:0] offset_ns;
        logic [63:0]        local_time_ns;
    } in_word_t;

    typedef struct packed {
        logic signed [30:0] adj_ppb;
        logic [1:0]         lock_state;
    } out_word_t;

endpackage

FILE: sv/clock_fll_servo_unit.sv
// ----------------------------------------------------------------------------
// clock_fll_servo_unit
// Frequency-locked clock servo: offset samples in, ppb adjustment and state out.
// ----------------------------------------------------------------------------
// One word is accepted per clock unless the output stalls, and each gives
// exactly one result word: the sample is captured in an input register, the
// whole servo update (sequencer, frequency estimate, slope, rounding and clamp)
// is one pass of logic into the output register, and the servo state is written
// back on the same edge, so the next sample can follow immediately. The input
// register doubles as a skid slot, so one more sample is taken while a result
// waits on m_ready. Configuration is written through cfg_* at any time the
// block is idle and takes effect on the next sample; cfg_ready is always high.
module clock_fll_servo_unit #(
    parameter logic [63:0] EST_INTERVAL_NS = cfs_pkg::EST_INTERVAL_NS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cfs_pkg::in_word_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cfs_pkg::out_word_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [46:0]       cfg_data
);
    import cfs_pkg::*;

    // pair spacing threshold with the 0.1 percent margin
    localparam logic [63:0] PAIR_LIMIT = (EST_INTERVAL_NS * 64'd1000 - 64'd1) / 64'd1001;
    localparam logic [63:0] RND_HALF   = 64'd1 << (FRAC_BITS - 1);

    // configuration registers
    logic [29:0]       max_ppb_reg;
    logic [46:0]       reset_thr_reg;
    logic [46:0]       jump_thr_reg;
    logic signed [3:0] interval_reg;

    // servo state
    phase_t             phase_reg, phase_next;
    logic               first_pass_reg, first_pass_next;
    logic signed [47:0] ref_offset_reg, ref_offset_next;
    logic [63:0]        ref_time_reg, ref_time_next;
    logic signed [63:0] freq_est_reg, freq_est_next;
    lock_state_t        last_state_reg, last_state_next;

    // pipeline registers
    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      m_valid_reg;
    out_word_t m_data_reg;

    logic      advance;
    logic      fire;
    out_word_t result;

    assign cfg_ready = 1'b1;
    assign advance   = !m_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_ppb_reg   <= MAX_PPB_RST;
            reset_thr_reg <= RESET_THR_RST;
            jump_thr_reg  <= JUMP_THR_RST;
            interval_reg  <= INTERVAL_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                REG_MAX_PPB:   max_ppb_reg   <= cfg_data[29:0];
                REG_RESET_THR: reset_thr_reg <= cfg_data;
                REG_JUMP_THR:  jump_thr_reg  <= cfg_data;
                REG_INTERVAL: begin
                    // minus eight folds onto the shortest interval
                    if (cfg_data[3:0] == 4'b1000) begin
                        interval_reg <= INTERVAL_MIN;
                    end else begin
                        interval_reg <= signed'(cfg_data[3:0]);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath terms
    logic signed [63:0] off64;
    logic signed [63:0] ref64;
    logic [47:0]        amag;
    logic [3:0]         shamt;
    logic signed [63:0] u_scaled;
    logic signed [63:0] slope_scaled;
    logic signed [63:0] f_new;
    logic signed [63:0] sum_q;
    logic signed [63:0] rnd;
    logic [29:0]        lim;
    logic signed [63:0] lim_s;
    logic signed [63:0] ppb_clamped;
    logic [63:0]        diff;
    logic               over_offset;
    logic               over_f_offset;

    always_comb begin
        off64         = {{16{in_word_reg.offset_ns[47]}}, in_word_reg.offset_ns};
        ref64         = {{16{ref_offset_reg[47]}}, ref_offset_reg};
        amag          = in_word_reg.offset_ns[47] ? 48'(-in_word_reg.offset_ns)
                                                  : 48'(in_word_reg.offset_ns);
        over_offset   = (reset_thr_reg != '0) && ({1'b0, reset_thr_reg} < amag);
        over_f_offset = (jump_thr_reg != '0) && ({1'b0, jump_thr_reg} < amag);
        // divide by 2^n in Q.7 is a left shift by 7-n
        shamt         = 4'(4'sd7 - interval_reg);
        u_scaled      = off64 <<< shamt;
        slope_scaled  = (off64 - ref64) <<< shamt;
        f_new         = freq_est_reg + ((u_scaled - freq_est_reg) >>> 2);
        sum_q         = f_new + slope_scaled;
        rnd           = (sum_q + signed'(RND_HALF)) >>> FRAC_BITS;
        lim           = (max_ppb_reg > ABS_MAX_PPB) ? ABS_MAX_PPB : max_ppb_reg;
        lim_s         = signed'({34'd0, lim});
        if (rnd < -lim_s) begin
            ppb_clamped = -lim_s;
        end else if (rnd > lim_s) begin
            ppb_clamped = lim_s;
        end else begin
            ppb_clamped = rnd;
        end
        diff          = in_word_reg.local_time_ns - ref_time_reg;
    end

    // sequencer next state and result
    always_comb begin
        phase_next        = phase_reg;
        first_pass_next   = first_pass_reg;
        ref_offset_next   = ref_offset_reg;
        ref_time_next     = ref_time_reg;
        freq_est_next     = freq_est_reg;
        last_state_next   = last_state_reg;
        result.adj_ppb    = '0;
        result.lock_state = last_state_reg;

        unique case (phase_reg)
            PH_SECOND: begin
                if (ref_time_reg >= in_word_reg.local_time_ns) begin
                    // out of order pair restarts
                    last_state_next = ST_UNLOCKED;
                    phase_next      = PH_FIRST;
                end else begin
                    if (!first_pass_reg || over_f_offset || over_offset) begin
                        last_state_next = ST_JUMP;
                    end else begin
                        last_state_next = ST_LOCKED;
                    end
                    first_pass_next = 1'b0;
                    ref_offset_next = '0;
                    ref_time_next   = '0;
                    phase_next      = PH_TRACK;
                end
            end
            PH_TRACK: begin
                if (over_offset) begin
                    last_state_next = ST_UNLOCKED;
                    phase_next      = PH_FIRST;
                end else if (ref_time_reg == '0) begin
                    // no reference held yet
                    ref_offset_next = in_word_reg.offset_ns;
                    ref_time_next   = in_word_reg.local_time_ns;
                end else if (diff > PAIR_LIMIT) begin
                    freq_est_next   = f_new;
                    result.adj_ppb  = 31'(ppb_clamped);
                    ref_time_next   = '0;
                    last_state_next = ST_LOCKED;
                end
            end
            default: begin
                // first sample, also the unused phase code
                ref_offset_next = in_word_reg.offset_ns;
                ref_time_next   = in_word_reg.local_time_ns;
                last_state_next = ST_UNLOCKED;
                phase_next      = PH_SECOND;
            end
        endcase

        result.lock_state = last_state_next;
    end

    // servo state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_FIRST;
            first_pass_reg <= 1'b1;
            ref_offset_reg <= '0;
            ref_time_reg   <= '0;
            freq_est_reg   <= '0;
            last_state_reg <= ST_UNLOCKED;
        end else if (fire) begin
            phase_reg      <= phase_next;
            first_pass_reg <= first_pass_next;
            ref_offset_reg <= ref_offset_next;
            ref_time_reg   <= ref_time_next;
            freq_est_reg   <= freq_est_next;
            last_state_reg <= last_state_next;
        end
    end

    // input word register, also the skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= result;
        end
    end

    // a nonzero adjustment only comes with a locked state
    a_adj_locked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.adj_ppb != '0) |-> m_data_reg.lock_state == ST_LOCKED)
        else $error("nonzero adjustment without lock");

    // adjustment never exceeds the absolute clamp
    a_adj_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.adj_ppb <= 31'sd900000000 &&
                         m_data_reg.adj_ppb >= -31'sd900000000))
        else $error("adjustment out of range");

    // input is held back only when both slots are full and output stalls
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without cause");

    // tracking always starts without a reference
    a_track_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && phase_reg == PH_SECOND && phase_next == PH_TRACK) |=>
            (ref_time_reg == '0 && !first_pass_reg))
        else $error("tracking entered with stale reference");

endmodule
